// File: rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, constants and the request and status bundles of the
// shared modular multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int DATA_W  = 31;
  localparam int BASE_W  = 32;
  localparam int EXPIN_W = 63;
  localparam int STEPS   = BASE_W;
  localparam int CNT_W   = $clog2(STEPS);

  localparam logic [DATA_W-1:0] DEFAULT_MODULUS = 31'd1000000007;

  typedef logic [DATA_W-1:0] data_t;

  typedef struct packed {
    logic              start;
    data_t             addend;
    logic [BASE_W-1:0] multiplier;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    data_t result;
  } mul_status_t;

endpackage

// File: rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// Shared modular multiplier
// Interleaved shift-and-add multiplication with reduction at every step,
// one multiplier bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module modexp_mulmod (
  input  logic                 clk,
  input  logic                 rst,
  input  modexp_pkg::data_t    modulus,
  input  modexp_pkg::mul_req_t req,
  output modexp_pkg::mul_status_t status
);

  logic                             active;
  logic                             finished;
  logic [modexp_pkg::CNT_W-1:0]     cnt;
  modexp_pkg::data_t                r;
  modexp_pkg::data_t                a;
  logic [modexp_pkg::BASE_W-1:0]    b;
  logic [modexp_pkg::DATA_W:0]      dbl;
  modexp_pkg::data_t                red;
  logic [modexp_pkg::DATA_W:0]      sum;
  modexp_pkg::data_t                r_next;

  always_comb begin
    dbl = {r, 1'b0};
    if (dbl >= {1'b0, modulus}) begin
      red = modexp_pkg::DATA_W'(dbl - {1'b0, modulus});
    end else begin
      red = dbl[modexp_pkg::DATA_W-1:0];
    end
    sum = {1'b0, red} + (b[modexp_pkg::BASE_W-1] ? {1'b0, a} : '0);
    if (sum >= {1'b0, modulus}) begin
      r_next = modexp_pkg::DATA_W'(sum - {1'b0, modulus});
    end else begin
      r_next = sum[modexp_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      cnt      <= '0;
      finished <= 1'b0;
    end else begin
      finished <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == modexp_pkg::CNT_W'(modexp_pkg::STEPS - 1)) begin
          active   <= 1'b0;
          finished <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      r <= '0;
      a <= req.addend;
      b <= req.multiplier;
    end else if (active) begin
      r <= r_next;
      b <= b << 1;
    end
  end

  assign status = '{done: finished, result: r};

endmodule

// File: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left binary square-and-multiply over one shared modular multiplier.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Transfer
//  input     start, busy, base, exponent      start high while busy low
//  result    done, power                      done high, one cycle only
//  config    modulus_we, modulus_wdata        modulus_we high
//
//  Each multiplication runs through the shared multiplier, which sets the rate.
//  An item first reduces the base, then for each exponent bit up to the highest
//  set one multiplies the accumulator if the bit is set and squares the base.
//  A zero modulus answers in the cycle after the transfer.
//  Reset brings back the default modulus. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int EXP_BITS = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [modexp_pkg::BASE_W-1:0]     base,
  input  logic [modexp_pkg::EXPIN_W-1:0]    exponent,
  output logic                              done,
  output logic [modexp_pkg::DATA_W-1:0]     power,
  input  logic                              modulus_we,
  input  logic [modexp_pkg::DATA_W-1:0]     modulus_wdata
);

  localparam int EXP_W = (EXP_BITS < modexp_pkg::EXPIN_W) ? EXP_BITS : modexp_pkg::EXPIN_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_REDUCE  = 3'd1;
  localparam logic [2:0] S_STEP    = 3'd2;
  localparam logic [2:0] S_MUL_ACC = 3'd3;
  localparam logic [2:0] S_MUL_SQ  = 3'd4;

  logic [2:0]                     state;
  modexp_pkg::data_t              modulus;
  modexp_pkg::data_t              acc;
  modexp_pkg::data_t              sq;
  logic [EXP_W-1:0]               rem;
  modexp_pkg::data_t              one;
  logic                           req_start;
  modexp_pkg::data_t              req_addend;
  logic [modexp_pkg::BASE_W-1:0]  req_multiplier;
  modexp_pkg::mul_req_t           req;
  modexp_pkg::mul_status_t        status;

  assign one  = (modulus == modexp_pkg::DATA_W'(1)) ? '0 : modexp_pkg::DATA_W'(1);
  assign busy = (state != S_IDLE);
  assign req  = '{start: req_start, addend: req_addend, multiplier: req_multiplier};

  modexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (req),
    .status  (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= modexp_pkg::DEFAULT_MODULUS;
    end else if (modulus_we) begin
      modulus <= modulus_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      req_start <= 1'b0;
    end else begin
      done      <= 1'b0;
      req_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (modulus == '0) begin
              done <= 1'b1;
            end else begin
              req_start <= 1'b1;
              state     <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (status.done) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (rem == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            req_start <= 1'b1;
            state     <= rem[0] ? S_MUL_ACC : S_MUL_SQ;
          end
        end
        S_MUL_ACC: begin
          if (status.done) begin
            req_start <= 1'b1;
            state     <= S_MUL_SQ;
          end
        end
        S_MUL_SQ: begin
          if (status.done) begin
            state <= S_STEP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rem            <= exponent[EXP_W-1:0];
        req_addend     <= one;
        req_multiplier <= base;
        power          <= '0;
      end
      S_REDUCE: begin
        if (status.done) begin
          sq  <= status.result;
          acc <= one;
        end
      end
      S_STEP: begin
        power          <= acc;
        req_addend     <= rem[0] ? acc : sq;
        req_multiplier <= modexp_pkg::BASE_W'(sq);
      end
      S_MUL_ACC: begin
        if (status.done) begin
          acc            <= status.result;
          req_addend     <= sq;
          req_multiplier <= modexp_pkg::BASE_W'(sq);
        end
      end
      S_MUL_SQ: begin
        if (status.done) begin
          sq  <= status.result;
          rem <= rem >> 1;
        end
      end
      default: begin
        rem <= '0;
      end
    endcase
  end

endmodule

// File: rtl/modexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level checks on the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module modexp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither started nor completed");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_busy_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result transfer");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("busy or done set after reset");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Offers base and exponent pairs through the start and busy handshake and
// predicts each power from its own square-and-multiply model. Every result
// strobe is checked against the oldest outstanding prediction. The modulus is
// rewritten between phases while the block is idle: the reset default, the
// smallest and largest legal values, zero and one, and random values.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BASE_W  = modexp_pkg::BASE_W;
  localparam int EXPIN_W = modexp_pkg::EXPIN_W;
  localparam int DATA_W  = modexp_pkg::DATA_W;

  typedef modexp_pkg::data_t data_t;

  localparam data_t DEFAULT_MODULUS = modexp_pkg::DEFAULT_MODULUS;

  localparam int EXP_BITS = 63;
  localparam logic [BASE_W-1:0]  BASE_MAX = {BASE_W{1'b1}};
  localparam logic [EXPIN_W-1:0] EXP_MAX  = {EXPIN_W{1'b1}};
  localparam data_t MODULUS_MAX = {DATA_W{1'b1}};

  logic                clk;
  logic                rst           = 1'b1;
  logic                start         = 1'b0;
  logic                busy;
  logic [BASE_W-1:0]   base          = '0;
  logic [EXPIN_W-1:0]  exponent      = '0;
  logic                done;
  data_t               power;
  logic                modulus_we    = 1'b0;
  data_t               modulus_wdata = '0;

  data_t modulus_model = DEFAULT_MODULUS;
  data_t expected_powers[$];
  int    failures      = 0;
  bit    steady        = 1'b0;

  modular_exponentiation #(
    .EXP_BITS(EXP_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .base         (base),
    .exponent     (exponent),
    .done         (done),
    .power        (power),
    .modulus_we   (modulus_we),
    .modulus_wdata(modulus_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic data_t expected_power(logic [BASE_W-1:0] b, logic [EXPIN_W-1:0] e,
                                           data_t m);
    logic [63:0]        acc;
    logic [63:0]        sq;
    logic [63:0]        m64;
    logic [EXPIN_W-1:0] rest;
    if (m == '0) begin
      return '0;
    end
    m64  = 64'(m);
    acc  = 64'd1 % m64;
    sq   = 64'(b) % m64;
    rest = e;
    for (int i = 0; i < EXP_BITS && rest != '0; i++) begin
      if (rest[0]) begin
        acc = (acc * sq) % m64;
      end
      sq   = (sq * sq) % m64;
      rest = rest >> 1;
    end
    return acc[DATA_W-1:0];
  endfunction

  function automatic logic [EXPIN_W-1:0] random_exponent();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      return '0;
    end else if (pick < 55) begin
      return EXPIN_W'($urandom_range(0, 255));
    end else if (pick < 80) begin
      return EXPIN_W'($urandom & 32'h000F_FFFF);
    end
    return EXPIN_W'({$urandom, $urandom});
  endfunction

  function automatic logic [BASE_W-1:0] random_base();
    if ($urandom_range(0, 99) < 30) begin
      return BASE_W'($urandom_range(0, 1000));
    end
    return BASE_W'($urandom);
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happened,
  // leaving start high so that the next item may follow without a gap.
  task automatic send_operands(logic [BASE_W-1:0] b, logic [EXPIN_W-1:0] e);
    if (!steady && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
    start    <= 1'b1;
    base     <= b;
    exponent <= e;
    do @(posedge clk); while (busy);
    expected_powers.push_back(expected_power(b, e, modulus_model));
  endtask

  task automatic wait_until_idle();
    start <= 1'b0;
    while (expected_powers.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_modulus(data_t value);
    wait_until_idle();
    modulus_we    <= 1'b1;
    modulus_wdata <= value;
    @(posedge clk);
    modulus_we    <= 1'b0;
    modulus_model  = value;
    @(posedge clk);
  endtask

  task automatic test_reset_modulus();
    send_operands('0, '0);
    send_operands('0, EXPIN_W'(1));
    send_operands('0, EXP_MAX);
    send_operands(BASE_MAX, '0);
    send_operands(BASE_MAX, EXPIN_W'(1));
    send_operands(BASE_MAX, EXP_MAX);
    send_operands(BASE_W'(1), EXP_MAX);
    send_operands(BASE_W'(2), EXPIN_W'(62));
    send_operands(BASE_W'(DEFAULT_MODULUS), EXPIN_W'(5));
    send_operands(BASE_W'(DEFAULT_MODULUS) + 1, EXPIN_W'(3));
    send_operands(BASE_MAX, EXPIN_W'(1) << (EXPIN_W - 1));
  endtask

  task automatic test_modulus_extremes();
    write_modulus(data_t'(2));
    send_operands(BASE_W'(3), EXP_MAX);
    send_operands(BASE_W'(2), EXPIN_W'(5));
    send_operands(BASE_MAX, '0);
    write_modulus(MODULUS_MAX);
    send_operands(BASE_MAX, EXP_MAX);
    send_operands(BASE_W'(MODULUS_MAX) - 1, EXPIN_W'(2));
    send_operands(BASE_W'(12345), EXPIN_W'({32'h5555_AAAA, 32'h0F0F_F0F0}));
  endtask

  // A zero modulus and a modulus of one both give a power of zero throughout.
  task automatic test_degenerate_modulus();
    write_modulus('0);
    send_operands(BASE_W'(7), '0);
    send_operands(BASE_MAX, EXP_MAX);
    write_modulus(data_t'(1));
    send_operands('0, '0);
    send_operands(BASE_W'(5), '0);
    send_operands(BASE_MAX, EXP_MAX);
  endtask

  task automatic random_phase(data_t m, int count, bit no_gaps);
    write_modulus(m);
    steady = no_gaps;
    repeat (count) send_operands(random_base(), random_exponent());
    steady = 1'b0;
  endtask

  task automatic test_random_operands();
    random_phase(data_t'($urandom_range(2, 32'h7FFF_FFFF)), 24, 1'b0);
    random_phase(data_t'($urandom_range(2, 100)), 24, 1'b0);
    random_phase(MODULUS_MAX, 24, 1'b1);
    random_phase(DEFAULT_MODULUS, 24, 1'b0);
    random_phase(data_t'($urandom_range(2, 32'h7FFF_FFFF)), 24, 1'b0);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_powers.size() == 0) begin
        $error("power: unexpected result %0d with nothing outstanding", power);
        failures++;
      end else begin
        if (power !== expected_powers[0]) begin
          $error("power: expected %0d, actual %0d", expected_powers[0], power);
          failures++;
        end
        void'(expected_powers.pop_front());
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_modulus();
    test_modulus_extremes();
    test_degenerate_modulus();
    test_random_operands();
    wait_until_idle();
    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("** modular_exponentiation: PASSED **");
    end else begin
      $display("** modular_exponentiation: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** modular_exponentiation: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
rtl/modexp_pkg.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation.sv
rtl/modexp_checker.sv
tb/sv/tb_top.sv
